FILE: design/pme_pkg.sv
package pme_pkg;

  // default operand width of the datapath
  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  // width of the fixed-size ports
  localparam int unsigned FIELD_WIDTH = 32;

  // modulus after reset
  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'hFFFF_FFFF;

endpackage

FILE: design/pme_step.sv
// one shift-and-add step of a modular multiplier: ((2*acc mod m) + addend) mod m
module pme_step #(
  parameter int unsigned OPERAND_WIDTH = pme_pkg::OPERAND_WIDTH_DEF
) (
  input  logic [OPERAND_WIDTH-1:0] acc,
  input  logic [OPERAND_WIDTH-1:0] addend,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  output logic [OPERAND_WIDTH-1:0] result
);

  logic [OPERAND_WIDTH:0] dbl;
  logic [OPERAND_WIDTH:0] dbl_red;
  logic [OPERAND_WIDTH:0] sum;
  logic [OPERAND_WIDTH:0] mod_ext;

  assign mod_ext = {1'b0, modulus};

  // acc < m, so 2*acc < 2m: one conditional subtract
  always_comb begin
    dbl = {acc, 1'b0};
    if (dbl >= mod_ext) begin
      dbl_red = dbl - mod_ext;
    end else begin
      dbl_red = dbl;
    end
    // addend <= m, so the sum stays below 2m
    sum = dbl_red + {1'b0, addend};
    if (sum >= mod_ext) begin
      sum = sum - mod_ext;
    end
  end

  assign result = sum[OPERAND_WIDTH-1:0];

endmodule

FILE: design/modular_exponentiation.sv
// modular exponentiation, square-and-multiply, one shared modular step unit
// modulus zero: no run starts and the result is zero
// throughput: one item at a time, busy for the whole run, multiplier scanned msb first
// reset: synchronous active-low rst_n, idle, no strobe, modulus = all ones (masked to W)
// the receiver cannot stall: each result shows for exactly one cycle on out_valid
module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH = pme_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [pme_pkg::FIELD_WIDTH-1:0]    in_base_value,
  input  logic [pme_pkg::FIELD_WIDTH-1:0]    in_exponent_value,
  // result channel
  output logic                               out_valid,
  output logic [pme_pkg::FIELD_WIDTH-1:0]    out_power_mod,
  // modulus write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pme_pkg::FIELD_WIDTH-1:0]    cfg_data
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

  // sequencer phases
  typedef enum logic [1:0] {
    S_IDLE,  // waiting for a start transfer
    S_RED,   // base mod m, one remainder bit per cycle
    S_SQR,   // acc * acc mod m
    S_MUL    // acc * base mod m
  } state_t;

  state_t          state_r;
  logic [W-1:0]    modulus_r;
  logic [W-1:0]    prod_r;      // running partial product of the current multiply
  logic [W-1:0]    x_r;         // multiplicand
  logic [W-1:0]    y_r;         // multiplier, scanned msb first by shifting left
  logic [W-1:0]    b_r;         // reduced base
  logic [W-1:0]    e_r;         // exponent, scanned msb first by shifting left
  logic [CW-1:0]   bit_cnt_r;   // bit of the current multiply or reduction
  logic [CW-1:0]   exp_cnt_r;   // exponent bits still to go
  logic            out_valid_r;
  logic [pme_pkg::FIELD_WIDTH-1:0] out_power_mod_r;

  logic [W-1:0]    base_w;
  logic [W-1:0]    exp_w;
  logic [W-1:0]    one_mod;     // 1 mod m
  logic [W-1:0]    addend;
  logic [W-1:0]    step_res;
  logic            mod_zero;

  // operands masked or zero-extended to the datapath width
  assign base_w   = W'(in_base_value);
  assign exp_w    = W'(in_exponent_value);
  assign mod_zero = (modulus_r == '0);
  assign one_mod  = (modulus_r == W'(1)) ? '0 : W'(1);

  // reduction feeds the next dividend bit; multiplies add x when the multiplier bit is set
  always_comb begin
    addend = '0;
    if (state_r == S_RED) begin
      addend = W'(y_r[W-1]);
    end else if (y_r[W-1]) begin
      addend = x_r;
    end
  end

  pme_step #(
    .OPERAND_WIDTH(W)
  ) u_step (
    .acc    (prod_r),
    .addend (addend),
    .modulus(modulus_r),
    .result (step_res)
  );

  // modulus register: configuration is to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(pme_pkg::MODULUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      modulus_r <= W'(cfg_data);
    end
  end

  // sequencer with datapath and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      exp_cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= start && mod_zero;
          if (start) begin
            if (mod_zero) begin
              // no valid modulus: answer zero at once
              out_power_mod_r <= '0;
            end else begin
              prod_r    <= '0;
              y_r       <= base_w;
              e_r       <= exp_w;
              bit_cnt_r <= LAST_BIT;
              state_r   <= S_RED;
            end
          end
        end
        S_RED: begin
          out_valid_r <= 1'b0;
          if (bit_cnt_r == '0) begin
            // base reduced; start squaring from acc = 1 mod m
            b_r       <= step_res;
            prod_r    <= '0;
            x_r       <= one_mod;
            y_r       <= one_mod;
            bit_cnt_r <= LAST_BIT;
            exp_cnt_r <= LAST_BIT;
            state_r   <= S_SQR;
          end else begin
            prod_r    <= step_res;
            y_r       <= {y_r[W-2:0], 1'b0};
            bit_cnt_r <= bit_cnt_r - CW'(1);
          end
        end
        S_SQR, S_MUL: begin
          if (bit_cnt_r == '0) begin
            prod_r    <= '0;
            bit_cnt_r <= LAST_BIT;
            if (state_r == S_SQR && e_r[W-1]) begin
              // exponent bit set: multiply by the base
              out_valid_r <= 1'b0;
              x_r         <= step_res;
              y_r         <= b_r;
              state_r     <= S_MUL;
            end else if (exp_cnt_r == '0) begin
              // last exponent bit done
              out_valid_r     <= 1'b1;
              out_power_mod_r <= pme_pkg::FIELD_WIDTH'(step_res);
              state_r         <= S_IDLE;
            end else begin
              // next exponent bit: square again
              out_valid_r <= 1'b0;
              exp_cnt_r   <= exp_cnt_r - CW'(1);
              e_r         <= {e_r[W-2:0], 1'b0};
              x_r         <= step_res;
              y_r         <= step_res;
              state_r     <= S_SQR;
            end
          end else begin
            out_valid_r <= 1'b0;
            prod_r      <= step_res;
            y_r         <= {y_r[W-2:0], 1'b0};
            bit_cnt_r   <= bit_cnt_r - CW'(1);
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_power_mod = out_power_mod_r;

  // a run only begins from a start transfer
  assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
    else $error("busy rose without a start transfer");

  // a result strobe leaves the block ready for the next command
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while busy");

  // every finished run delivers its result
  assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> out_valid)
    else $error("run ended without a result strobe");

endmodule

FILE: dv/modexp_checker.sv
module modexp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [pme_pkg::FIELD_WIDTH-1:0] in_base_value,
  input  logic [pme_pkg::FIELD_WIDTH-1:0] in_exponent_value,
  input  logic                            out_valid,
  input  logic [pme_pkg::FIELD_WIDTH-1:0] out_power_mod,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pme_pkg::FIELD_WIDTH-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              outstanding
);

  typedef logic [pme_pkg::FIELD_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t base;
    word_t expo;
    word_t modulus;
    word_t power;
  } power_job_t;

  word_t      modulus_q;
  power_job_t pending_powers[$];

  // square-and-multiply from the top exponent bit, exact 64-bit products
  function automatic word_t expected_power(word_t base, word_t expo, word_t m);
    logic [63:0] acc;
    logic [63:0] b;
    if (m == '0) return '0;
    b   = {32'd0, base} % {32'd0, m};
    acc = 64'd1 % {32'd0, m};
    for (int bit_idx = pme_pkg::FIELD_WIDTH - 1; bit_idx >= 0; bit_idx--) begin
      acc = (acc * acc) % {32'd0, m};
      if (expo[bit_idx]) acc = (acc * b) % {32'd0, m};
    end
    return acc[pme_pkg::FIELD_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    power_job_t job;
    if (!rst_n) begin
      modulus_q = pme_pkg::MODULUS_RESET;
      pending_powers.delete();
    end else begin
      if (out_valid) begin
        if (pending_powers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: power %h", out_power_mod);
        end else begin
          job = pending_powers.pop_front();
          if (out_power_mod !== job.power) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("power mismatch: base %h exp %h mod %h expected %h actual %h",
                       job.base, job.expo, job.modulus, job.power, out_power_mod);
          end
        end
      end
      if (start && !busy) begin
        job.base    = in_base_value;
        job.expo    = in_exponent_value;
        job.modulus = modulus_q;
        job.power   = expected_power(in_base_value, in_exponent_value, modulus_q);
        pending_powers.push_back(job);
      end
      if (cfg_valid && cfg_ready) modulus_q = cfg_data;
    end
    outstanding = pending_powers.size();
  end

endmodule

FILE: dv/modular_exponentiation_tb.sv
module modular_exponentiation_tb;

  typedef logic [pme_pkg::FIELD_WIDTH-1:0] word_t;

  // every block input starts at a known value
  logic  clk               = 1'b0;
  logic  rst_n             = 1'b0;
  logic  start             = 1'b0;
  word_t in_base_value     = '0;
  word_t in_exponent_value = '0;
  logic  cfg_valid         = 1'b0;
  word_t cfg_data          = '0;

  logic  busy;
  logic  out_valid;
  word_t out_power_mod;
  logic  cfg_ready;

  int mismatch_count;
  int outstanding;

  modular_exponentiation dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .out_valid         (out_valid),
    .out_power_mod     (out_power_mod),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // watches all three channels, predicts each power and compares
  modexp_checker power_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .out_valid         (out_valid),
    .out_power_mod     (out_power_mod),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding)
  );

  initial forever #4 clk = ~clk;

  // hang guard: the limit covers every item at its worst case plus the long gaps, with plenty of room
  initial begin
    repeat (10_000_000) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // present one command and hold it until the transfer; busy only moves at the
  // rising edge, so its value at the falling edge decides the transfer
  task automatic issue_power(input word_t base, input word_t expo);
    bit taken;
    start             <= 1'b1;
    in_base_value     <= base;
    in_exponent_value <= expo;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // sender gap: start held low, n sets the length of the gap
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every predicted power has come back and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
    @(posedge clk);
  endtask

  // modulus writes happen only with the block drained
  task automatic write_modulus(input word_t m);
    bit taken;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  // bases biased toward zero, tiny values and the region around the modulus
  function automatic word_t pick_base(input word_t m);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return word_t'($urandom_range(0, 3));
      2:       return m - 1;
      3:       return m + word_t'($urandom_range(0, 7));
      default: return word_t'($urandom);
    endcase
  endfunction

  // exponents: half random full width, the rest zero, all ones or short
  function automatic word_t pick_exponent();
    case ($urandom_range(0, 7)) inside
      0:       return '0;
      1:       return '1;
      [2:3]:   return word_t'($urandom_range(0, 64));
      default: return word_t'($urandom);
    endcase
  endfunction

  // random items in bursts; some gaps are long enough to land anywhere in a run,
  // others short, and some bursts follow each other with no gap at all
  task automatic run_random(input int count, input word_t m);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && left > 0; i++) begin
        issue_power(pick_base(m), pick_exponent());
        left--;
      end
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 2500));
      else if ($urandom_range(0, 1) == 0) idle_cycles($urandom_range(1, 5));
    end
  endtask

  initial begin
    word_t m;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset modulus, all ones: operand extremes and wraparound of powers of two
    issue_power('0, '0);
    issue_power('1, '1);
    issue_power('1, '0);
    issue_power('0, '1);
    issue_power(32'd2, 32'd31);
    issue_power(32'd2, 32'd32);
    issue_power(32'd3, 32'h8000_0000);
    issue_power(32'd1, '1);

    // modulus one, every power is zero, including exponent zero
    write_modulus(32'd1);
    issue_power(32'd5, '0);
    issue_power('1, '1);

    // small modulus, bases at and above it
    write_modulus(32'd7);
    issue_power(32'd7, 32'd3);
    issue_power(32'd100, 32'd5);
    issue_power('1, 32'd2);

    // largest prime below 2^32
    write_modulus(32'hFFFF_FFFB);
    issue_power('1, 32'hFFFF_FFFA);
    issue_power(32'hFFFF_FFFA, 32'd2);

    // single top bit modulus
    write_modulus(32'h8000_0000);
    issue_power(32'd3, '1);
    issue_power(32'h8000_0001, 32'd1);

    // modulus zero lies outside the range, the block answers zero
    write_modulus('0);
    issue_power(32'd5, 32'd7);

    write_modulus(32'd2);
    issue_power('1, 32'd1);
    issue_power(32'd2, '0);

    // random phases, each under its own modulus
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       m = pme_pkg::MODULUS_RESET;
        1:       m = word_t'($urandom_range(2, 65536));
        2:       m = 32'd1;
        3:       m = word_t'($urandom) | 32'd1;
        4:       m = 32'hFFFF_FFFB;
        default: m = word_t'($urandom) | 32'h8000_0000;
      endcase
      write_modulus(m);
      run_random((ph == 2) ? 10 : 58, m);
    end

    // drain, then watch a full worst-case latency for stray result transfers
    wait_drained();
    repeat (2100) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pme_pkg.sv
design/pme_step.sv
design/modular_exponentiation.sv
dv/modexp_checker.sv
dv/modular_exponentiation_tb.sv
